>>> sv/fcs_pkg.sv
// ============================================================================
// fcs_pkg : shared types and constants for the filled circle span generator
// Holds the controller states, command/status structs and the row rounding.
// ============================================================================
package fcs_pkg;

    // Fixed-point walk coordinate: 6 fraction bits, signed
    localparam int WALK_W = 13;
    // Rounded row / half-width value (0..64)
    localparam int ROW_W = 7;
    // Fraction bits and rounding half
    localparam int FRAC_BITS = 6;
    localparam logic [WALK_W-1:0] FRAC_HALF = 13'd32;
    // Opaque alpha, no blending needed
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SINGLE,
        ST_ROUND,
        ST_A_CHK,
        ST_A_DOWN,
        ST_A_UP,
        ST_B_CHK,
        ST_B_DOWN,
        ST_B_UP,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_FLUSH
    } fcs_state_t;

    // Which span the datapath builds on a push
    typedef enum logic [1:0] {
        SPAN_ERR,
        SPAN_ZERO,
        SPAN_A,
        SPAN_B
    } fcs_span_t;

    typedef struct packed {
        logic      load;      // capture request, init walk
        logic      round;     // register rounded rows
        logic      push;      // build a span into the pending slot
        fcs_span_t span_sel;
        logic      up;        // span above the centre
        logic      mark_i;    // update row tracker i
        logic      mark_h;    // update row tracker h
        logic      div_x_go;  // start iy / radius
        logic      div_y_go;  // start ix / radius
        logic      upd_ix;    // ix += quotient
        logic      upd_iy;    // iy -= quotient
        logic      flush;     // send pending span as the last one
    } fcs_cmd_t;

    typedef struct packed {
        logic neg;        // negative radius
        logic zero;       // zero radius
        logic a_ok;       // row i not yet drawn
        logic b_ok;       // row h not yet drawn
        logic i_pos;      // row i above zero
        logic h_pos;      // row h above zero
        logic walk_more;  // i > h, keep walking
        logic div_done;
        logic out_free;   // output register can take a span
    } fcs_stat_t;

    // Round a 6-fraction-bit value to a whole row, negatives give 0
    function automatic logic [ROW_W-1:0] round6(input logic signed [WALK_W-1:0] v);
        logic [WALK_W-1:0] s;
        s = {1'b0, v[WALK_W-2:0]} + FRAC_HALF;
        return v[WALK_W-1] ? '0 : s[WALK_W-1:FRAC_BITS];
    endfunction

endpackage

>>> sv/fcs_div.sv
// ============================================================================
// fcs_div : small signed-by-radius divider
// Restoring division of a signed walk value by a 5-bit radius, four quotient
// bits per cycle, truncating toward zero.
// ============================================================================
module fcs_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [fcs_pkg::WALK_W-1:0]   dividend,
    input  logic        [4:0]                   divisor,
    output logic signed [fcs_pkg::WALK_W-1:0]   quotient,
    output logic                                done
);

    localparam int MagW       = fcs_pkg::WALK_W - 1;
    localparam int StepsPerCy = 4;
    localparam int Cycles     = MagW / StepsPerCy;

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [1:0]       cnt_reg;
    logic [4:0]       rem_reg;
    logic [4:0]       den_reg;
    logic [MagW-1:0]  quo_reg;

    logic [fcs_pkg::WALK_W-1:0] mag;
    logic [4:0]       rem_next;
    logic [MagW-1:0]  quo_next;
    logic [5:0]       trial;

    // Magnitude of the dividend
    always_comb
    begin
        mag = dividend[fcs_pkg::WALK_W-1] ? (13'd0 - dividend) : dividend;
    end

    // Four restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < StepsPerCy; k++)
        begin
            trial    = {rem_next, quo_next[MagW-1]};
            quo_next = {quo_next[MagW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = 5'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[4:0];
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(Cycles - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[fcs_pkg::WALK_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= mag[MagW-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign done     = done_reg;

endmodule

>>> sv/fcs_datapath.sv
// ============================================================================
// fcs_datapath : walk registers, span builder and output stage
// Keeps the fixed-point walk, the row trackers, one pending span and the
// output register; acts on commands from the controller.
// ============================================================================
module fcs_datapath #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fcs_pkg::fcs_cmd_t       cmd,
    output fcs_pkg::fcs_stat_t      stat,
    input  logic signed [15:0]      center_x,
    input  logic signed [15:0]      center_y,
    input  logic signed [5:0]       radius,
    input  logic        [7:0]       red,
    input  logic        [7:0]       green,
    input  logic        [7:0]       blue,
    input  logic        [7:0]       alpha,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      x_left,
    output logic signed [15:0]      x_right,
    output logic signed [15:0]      y_row,
    output logic        [7:0]       span_red,
    output logic        [7:0]       span_green,
    output logic        [7:0]       span_blue,
    output logic        [7:0]       span_alpha,
    output logic                    blend_on,
    output logic                    bad_radius,
    output logic                    last_span
);

    localparam int WW = fcs_pkg::WALK_W;
    localparam int RW = fcs_pkg::ROW_W;

    // Request
    logic [15:0] cx_reg;
    logic [15:0] cy_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [4:0]  rad_reg;
    logic        neg_reg;

    // Walk
    logic signed [WW-1:0] ix_reg;
    logic signed [WW-1:0] iy_reg;
    logic [RW-1:0] h_reg;
    logic [RW-1:0] i_reg;
    logic [RW-1:0] last_i_reg;
    logic [RW-1:0] last_h_reg;
    logic          vi_reg;
    logic          vh_reg;

    // Pending span
    logic        pend_valid_reg;
    logic [15:0] pend_xl_reg;
    logic [15:0] pend_xr_reg;
    logic [15:0] pend_yr_reg;
    logic        pend_bad_reg;

    // Output stage
    logic        out_valid_reg;
    logic [15:0] out_xl_reg;
    logic [15:0] out_xr_reg;
    logic [15:0] out_yr_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic [7:0]  out_alpha_reg;
    logic        out_blend_reg;
    logic        out_bad_reg;
    logic        out_last_reg;

    logic [4:0]  rad_in;
    logic [RW-1:0] half;
    logic [RW-1:0] row;
    logic [15:0] span_xl;
    logic [15:0] span_xr;
    logic [15:0] span_yr;
    logic        xfer;
    logic        out_free;
    logic        div_go;
    logic signed [WW-1:0] div_num;
    logic signed [WW-1:0] div_quo;
    logic        div_done;

    // Clamp radius
    assign rad_in = (radius[4:0] > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius[4:0];

    // Divider shared by both walk updates
    assign div_go  = cmd.div_x_go || cmd.div_y_go;
    assign div_num = cmd.div_x_go ? iy_reg : ix_reg;

    fcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_num),
        .divisor  (rad_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Span builder
    always_comb
    begin
        case (cmd.span_sel)
            fcs_pkg::SPAN_A:
            begin
                half = h_reg;
                row  = i_reg;
            end
            fcs_pkg::SPAN_B:
            begin
                half = i_reg;
                row  = h_reg;
            end
            default:
            begin
                half = '0;
                row  = '0;
            end
        endcase
        span_xl = cx_reg - {9'd0, half};
        span_xr = cx_reg + {9'd0, half};
        span_yr = cmd.up ? (cy_reg - {9'd0, row}) : (cy_reg + {9'd0, row});
    end

    // Pending span moves out on a push behind it or on the final flush
    assign out_free = !out_valid_reg || !out_stall;
    assign xfer     = (cmd.push && pend_valid_reg) || cmd.flush;

    // Status
    always_comb
    begin
        stat.neg       = neg_reg;
        stat.zero      = (rad_reg == 5'd0);
        stat.a_ok      = (!vi_reg || last_i_reg != i_reg) && (!vh_reg || last_h_reg != i_reg);
        stat.b_ok      = (!vh_reg || last_h_reg != h_reg) && (!vi_reg || last_i_reg != h_reg)
                         && (i_reg != h_reg);
        stat.i_pos     = (i_reg != '0);
        stat.h_pos     = (h_reg != '0);
        stat.walk_more = (i_reg > h_reg);
        stat.div_done  = div_done;
        stat.out_free  = out_free;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            vi_reg         <= 1'b0;
            vh_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                vi_reg <= 1'b0;
                vh_reg <= 1'b0;
            end
            if (cmd.mark_i)
                vi_reg <= 1'b1;
            if (cmd.mark_h)
                vh_reg <= 1'b1;

            if (cmd.flush)
                pend_valid_reg <= 1'b0;
            else if (cmd.push)
                pend_valid_reg <= 1'b1;

            if (xfer)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
            neg_reg   <= radius[5];
            rad_reg   <= rad_in;
            ix_reg    <= '0;
            iy_reg    <= $signed({2'b00, rad_in, 6'b000000});
        end
        if (cmd.round)
        begin
            h_reg <= fcs_pkg::round6(ix_reg);
            i_reg <= fcs_pkg::round6(iy_reg);
        end
        if (cmd.mark_i)
            last_i_reg <= i_reg;
        if (cmd.mark_h)
            last_h_reg <= h_reg;
        if (cmd.upd_ix)
            ix_reg <= ix_reg + div_quo;
        if (cmd.upd_iy)
            iy_reg <= iy_reg - div_quo;
    end

    // Pending span payload
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            if (cmd.span_sel == fcs_pkg::SPAN_ERR)
            begin
                pend_xl_reg  <= '0;
                pend_xr_reg  <= '0;
                pend_yr_reg  <= '0;
                pend_bad_reg <= 1'b1;
            end
            else
            begin
                pend_xl_reg  <= span_xl;
                pend_xr_reg  <= span_xr;
                pend_yr_reg  <= span_yr;
                pend_bad_reg <= 1'b0;
            end
        end
    end

    // Output register payload; error result carries no colour
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            out_xl_reg    <= pend_xl_reg;
            out_xr_reg    <= pend_xr_reg;
            out_yr_reg    <= pend_yr_reg;
            out_red_reg   <= pend_bad_reg ? 8'd0 : red_reg;
            out_green_reg <= pend_bad_reg ? 8'd0 : green_reg;
            out_blue_reg  <= pend_bad_reg ? 8'd0 : blue_reg;
            out_alpha_reg <= pend_bad_reg ? 8'd0 : alpha_reg;
            out_blend_reg <= !pend_bad_reg && (alpha_reg != fcs_pkg::ALPHA_OPAQUE);
            out_bad_reg   <= pend_bad_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_left     = out_xl_reg;
    assign x_right    = out_xr_reg;
    assign y_row      = out_yr_reg;
    assign span_red   = out_red_reg;
    assign span_green = out_green_reg;
    assign span_blue  = out_blue_reg;
    assign span_alpha = out_alpha_reg;
    assign blend_on   = out_blend_reg;
    assign bad_radius = out_bad_reg;
    assign last_span  = out_last_reg;

    // Checks
    ap_xfer_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.flush) |-> (!out_valid_reg || !out_stall))
        else $error("span moved into a busy output register");

    ap_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> pend_valid_reg)
        else $error("flush with no pending span");

    ap_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("pending span left after flush");

    ap_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> out_last_reg)
        else $error("error result not marked last");

endmodule

>>> sv/fcs_ctrl.sv
// ============================================================================
// fcs_ctrl : span generator sequencer
// Steps through setup, one span for a negative or zero radius, the per-row
// emit checks, the two divisions of each walk step and the final flush.
// ============================================================================
module fcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fcs_pkg::fcs_stat_t  stat,
    output fcs_pkg::fcs_cmd_t   cmd
);

    fcs_pkg::fcs_state_t state_reg;
    fcs_pkg::fcs_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fcs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcs_pkg::ST_IDLE:
                if (in_valid)
                    state_next = fcs_pkg::ST_SETUP;
            fcs_pkg::ST_SETUP:
                state_next = (stat.neg || stat.zero) ? fcs_pkg::ST_SINGLE : fcs_pkg::ST_ROUND;
            fcs_pkg::ST_SINGLE:
                if (stat.out_free)
                    state_next = fcs_pkg::ST_FLUSH;
            fcs_pkg::ST_ROUND:
                state_next = fcs_pkg::ST_A_CHK;
            fcs_pkg::ST_A_CHK:
                state_next = stat.a_ok ? fcs_pkg::ST_A_DOWN : fcs_pkg::ST_B_CHK;
            fcs_pkg::ST_A_DOWN:
                if (stat.out_free)
                    state_next = stat.i_pos ? fcs_pkg::ST_A_UP : fcs_pkg::ST_B_CHK;
            fcs_pkg::ST_A_UP:
                if (stat.out_free)
                    state_next = fcs_pkg::ST_B_CHK;
            fcs_pkg::ST_B_CHK:
                state_next = stat.b_ok ? fcs_pkg::ST_B_DOWN : fcs_pkg::ST_DX_GO;
            fcs_pkg::ST_B_DOWN:
                if (stat.out_free)
                    state_next = stat.h_pos ? fcs_pkg::ST_B_UP : fcs_pkg::ST_DX_GO;
            fcs_pkg::ST_B_UP:
                if (stat.out_free)
                    state_next = fcs_pkg::ST_DX_GO;
            fcs_pkg::ST_DX_GO:
                state_next = fcs_pkg::ST_DX_WAIT;
            fcs_pkg::ST_DX_WAIT:
                if (stat.div_done)
                    state_next = fcs_pkg::ST_DY_GO;
            fcs_pkg::ST_DY_GO:
                state_next = fcs_pkg::ST_DY_WAIT;
            fcs_pkg::ST_DY_WAIT:
                if (stat.div_done)
                    state_next = stat.walk_more ? fcs_pkg::ST_ROUND : fcs_pkg::ST_FLUSH;
            fcs_pkg::ST_FLUSH:
                if (stat.out_free)
                    state_next = fcs_pkg::ST_IDLE;
            default:
                state_next = fcs_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != fcs_pkg::ST_IDLE);
        case (state_reg)
            fcs_pkg::ST_IDLE:
                cmd.load = in_valid;
            fcs_pkg::ST_SINGLE:
            begin
                cmd.push     = stat.out_free;
                cmd.span_sel = stat.neg ? fcs_pkg::SPAN_ERR : fcs_pkg::SPAN_ZERO;
            end
            fcs_pkg::ST_ROUND:
                cmd.round = 1'b1;
            fcs_pkg::ST_A_DOWN:
            begin
                cmd.push     = stat.out_free;
                cmd.mark_i   = stat.out_free;
                cmd.span_sel = fcs_pkg::SPAN_A;
            end
            fcs_pkg::ST_A_UP:
            begin
                cmd.push     = stat.out_free;
                cmd.span_sel = fcs_pkg::SPAN_A;
                cmd.up       = 1'b1;
            end
            fcs_pkg::ST_B_DOWN:
            begin
                cmd.push     = stat.out_free;
                cmd.mark_h   = stat.out_free;
                cmd.span_sel = fcs_pkg::SPAN_B;
            end
            fcs_pkg::ST_B_UP:
            begin
                cmd.push     = stat.out_free;
                cmd.span_sel = fcs_pkg::SPAN_B;
                cmd.up       = 1'b1;
            end
            fcs_pkg::ST_DX_GO:
                cmd.div_x_go = 1'b1;
            fcs_pkg::ST_DX_WAIT:
                cmd.upd_ix = stat.div_done;
            fcs_pkg::ST_DY_GO:
                cmd.div_y_go = 1'b1;
            fcs_pkg::ST_DY_WAIT:
                cmd.upd_iy = stat.div_done;
            fcs_pkg::ST_FLUSH:
                cmd.flush = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

    // Checks
    ap_push_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.flush))
        else $error("push and flush in the same cycle");

    ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == fcs_pkg::ST_SETUP))
        else $error("request load did not start setup");

    ap_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_x_go || cmd.div_y_go) |=> !stat.div_done)
        else $error("divider done right after start");

endmodule

>>> sv/filled_circle_span_generator.sv
// ============================================================================
// filled_circle_span_generator : horizontal spans filling a disc
// A request is taken only while idle, once the previous disc's last span is flushed.
// A negative or zero radius gives a single span. Each walk step runs the two
// radius divisions in one shared divider (4 bits per cycle).
// Reset clears the sequencer and the output valid; no request is in flight.
// ============================================================================
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  center_x,
    input  logic signed [15:0]  center_y,
    input  logic signed [5:0]   radius,
    input  logic        [7:0]   red,
    input  logic        [7:0]   green,
    input  logic        [7:0]   blue,
    input  logic        [7:0]   alpha,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  x_left,
    output logic signed [15:0]  x_right,
    output logic signed [15:0]  y_row,
    output logic        [7:0]   span_red,
    output logic        [7:0]   span_green,
    output logic        [7:0]   span_blue,
    output logic        [7:0]   span_alpha,
    output logic                blend_on,
    output logic                bad_radius,
    output logic                last_span
);

    fcs_pkg::fcs_cmd_t  cmd;
    fcs_pkg::fcs_stat_t stat;

    // Sequencer
    fcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Walk, span builder and output register
    fcs_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .x_left     (x_left),
        .x_right    (x_right),
        .y_row      (y_row),
        .span_red   (span_red),
        .span_green (span_green),
        .span_blue  (span_blue),
        .span_alpha (span_alpha),
        .blend_on   (blend_on),
        .bad_radius (bad_radius),
        .last_span  (last_span)
    );

endmodule
